@@ src/gnf_pkg.sv @@
`default_nettype none

package gnf_pkg;

  localparam int P_W   = 56;
  localparam int SUM_W = 60;
  localparam int TOT_W = 21;
  localparam int WGT_W = 17;
  localparam int CNT_W = 5;

  localparam logic [29:0] K_HX   = 30'd374761393;
  localparam logic [29:0] K_HY   = 30'd668265263;
  localparam logic [30:0] K_SEED = 31'd1442695041;
  localparam logic [30:0] K_MIX  = 31'd1274126177;

  localparam logic signed [17:0] G_ONE  = 18'sd65536;
  localparam logic signed [17:0] G_DIAG = 18'sd46341;

  localparam logic [1:0] REG_SEED        = 2'd0;
  localparam logic [1:0] REG_SCALE_RECIP = 2'd1;
  localparam logic [1:0] REG_OCTAVES     = 2'd2;
  localparam logic [1:0] REG_PERSISTENCE = 2'd3;

  localparam logic [2:0] GR_PX  = 3'd0;
  localparam logic [2:0] GR_NX  = 3'd1;
  localparam logic [2:0] GR_PY  = 3'd2;
  localparam logic [2:0] GR_NY  = 3'd3;
  localparam logic [2:0] GR_PP  = 3'd4;
  localparam logic [2:0] GR_NP  = 3'd5;
  localparam logic [2:0] GR_PN  = 3'd6;
  localparam logic [2:0] GR_NN  = 3'd7;

  typedef struct packed {
    logic signed [P_W-1:0]   px;
    logic signed [P_W-1:0]   py;
    logic signed [SUM_W-1:0] sum;
    logic [WGT_W-1:0]        weight;
    logic [TOT_W-1:0]        total;
  } bundle_t;

  typedef struct packed {
    logic [63:0]      seed_term;
    logic [15:0]      persistence;
    logic [CNT_W-1:0] octaves;
  } cfg_t;

  function automatic logic signed [17:0] grad_x(input logic [2:0] g);
    logic signed [17:0] r;
    case (g)
      GR_PX:   r = G_ONE;
      GR_NX:   r = -G_ONE;
      GR_PY:   r = 18'sd0;
      GR_NY:   r = 18'sd0;
      GR_PP:   r = G_DIAG;
      GR_NP:   r = -G_DIAG;
      GR_PN:   r = G_DIAG;
      GR_NN:   r = -G_DIAG;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] grad_y(input logic [2:0] g);
    logic signed [17:0] r;
    case (g)
      GR_PX:   r = 18'sd0;
      GR_NX:   r = 18'sd0;
      GR_PY:   r = G_ONE;
      GR_NY:   r = -G_ONE;
      GR_PP:   r = G_DIAG;
      GR_NP:   r = G_DIAG;
      GR_PN:   r = -G_DIAG;
      GR_NN:   r = -G_DIAG;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/gnf_cell.sv @@
`default_nettype none

module gnf_cell
  import gnf_pkg::*;
#(
  parameter int OCT = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  input  wire bundle_t in_b,
  output logic         out_valid,
  output bundle_t      out_b
);

  localparam int SH = 40 - OCT;
  localparam int DLY = 11;

  // stage 1: cell index and hash products
  logic signed [31:0] ix, iy;
  logic signed [61:0] a_full, b_full;
  logic [63:0] a_r, b_r;
  logic [15:0] fx1_r, fy1_r;

  assign ix = 32'($signed(in_b.px) >>> SH);
  assign iy = 32'($signed(in_b.py) >>> SH);
  assign a_full = ix * $signed({1'b0, K_HX});
  assign b_full = iy * $signed({1'b0, K_HY});

  always_ff @(posedge clk) begin
    a_r <= {{2{a_full[61]}}, a_full};
    b_r <= {{2{b_full[61]}}, b_full};
    fx1_r <= in_b.px[39-OCT -: 16];
    fy1_r <= in_b.py[39-OCT -: 16];
  end

  // stage 2: base hash, smoothstep factors
  logic [63:0] base_r;
  logic [31:0] ffx_r, ffy_r;
  logic [17:0] gx_r, gy_r;
  logic [15:0] fx2_r, fy2_r;

  always_ff @(posedge clk) begin
    base_r <= a_r + b_r + cfg.seed_term;
    ffx_r <= fx1_r * fx1_r;
    ffy_r <= fy1_r * fy1_r;
    gx_r <= 18'd196608 - {1'b0, fx1_r, 1'b0};
    gy_r <= 18'd196608 - {1'b0, fy1_r, 1'b0};
    fx2_r <= fx1_r;
    fy2_r <= fy1_r;
  end

  // stage 3: corner hashes, first xor-shift
  logic [63:0] off [4];
  logic [63:0] hc [4];
  logic [47:0] x1_r [4];
  logic [49:0] smx, smy;
  logic [15:0] u3_r, v3_r, fx3_r, fy3_r;

  assign off[0] = 64'd0;
  assign off[1] = {34'd0, K_HX};
  assign off[2] = {34'd0, K_HY};
  assign off[3] = {34'd0, K_HX} + {34'd0, K_HY};
  assign smx = ffx_r * gx_r;
  assign smy = ffy_r * gy_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hc[c] = base_r + off[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      x1_r[c] <= hc[c][47:0] ^ hc[c][60:13];
    end
    u3_r <= smx[47:32];
    v3_r <= smy[47:32];
    fx3_r <= fx2_r;
    fy3_r <= fy2_r;
  end

  // stage 4: mixing multiply in two halves
  logic [54:0] plo [4];
  logic [54:0] phi [4];
  logic [47:0] plo_r [4];
  logic [23:0] phi_r [4];
  logic [15:0] u4_r, v4_r, fx4_r, fy4_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      plo[c] = x1_r[c][23:0] * K_MIX;
      phi[c] = x1_r[c][47:24] * K_MIX;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      plo_r[c] <= plo[c][47:0];
      phi_r[c] <= phi[c][23:0];
    end
    u4_r <= u3_r;
    v4_r <= v3_r;
    fx4_r <= fx3_r;
    fy4_r <= fy3_r;
  end

  // stage 5: gradient select, all-ones word wraps to gradient 0
  logic [47:0] h2 [4];
  logic [31:0] lw [4];
  logic [2:0] g_r [4];
  logic [15:0] u5_r, v5_r, fx5_r, fy5_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h2[c] = plo_r[c] + {phi_r[c], 24'd0};
      lw[c] = h2[c][31:0] ^ h2[c][47:16];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      g_r[c] <= (&lw[c]) ? GR_PX : lw[c][31:29];
    end
    u5_r <= u4_r;
    v5_r <= v4_r;
    fx5_r <= fx4_r;
    fy5_r <= fy4_r;
  end

  // stage 6: corner dot products
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [35:0] dot_c [4];
  logic signed [35:0] dot_r [4];
  logic [15:0] u6_r, v6_r;

  assign dx0 = $signed({2'b00, fx5_r});
  assign dy0 = $signed({2'b00, fy5_r});
  assign dx1 = dx0 - G_ONE;
  assign dy1 = dy0 - G_ONE;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dot_c[c] = grad_x(g_r[c]) * (c[0] ? dx1 : dx0) + grad_y(g_r[c]) * (c[1] ? dy1 : dy0);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      dot_r[c] <= dot_c[c];
    end
    u6_r <= u5_r;
    v6_r <= v5_r;
  end

  // stages 7..8: blend along x
  logic signed [36:0] dfa, dfb;
  logic signed [53:0] ma_r, mb_r;
  logic signed [35:0] n0_r, n2_r;
  logic [15:0] v7_r, v8_r;
  logic signed [37:0] a8_r, b8_r;

  assign dfa = 37'(dot_r[1]) - 37'(dot_r[0]);
  assign dfb = 37'(dot_r[3]) - 37'(dot_r[2]);

  always_ff @(posedge clk) begin
    ma_r <= dfa * $signed({1'b0, u6_r});
    mb_r <= dfb * $signed({1'b0, u6_r});
    n0_r <= dot_r[0];
    n2_r <= dot_r[2];
    v7_r <= v6_r;
    a8_r <= 38'(n0_r) + 38'(ma_r >>> 16);
    b8_r <= 38'(n2_r) + 38'(mb_r >>> 16);
    v8_r <= v7_r;
  end

  // stages 9..10: blend along y, map to octave value
  logic signed [38:0] dfc;
  logic signed [55:0] mc_r;
  logic signed [37:0] a9_r;
  logic signed [39:0] nsum;
  logic signed [39:0] val_r;

  assign dfc = 39'(b8_r) - 39'(a8_r);
  assign nsum = 40'(a9_r) + 40'(mc_r >>> 16);

  always_ff @(posedge clk) begin
    mc_r <= dfc * $signed({1'b0, v8_r});
    a9_r <= a8_r;
    val_r <= (nsum >>> 1) + 40'sd2147483648;
  end

  // carried item and valid line
  bundle_t dly_r [DLY];
  logic vld_r [DLY];

  always_ff @(posedge clk) begin
    dly_r[0] <= in_b;
    for (int i = 1; i < DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DLY; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stages 11..12: weighting and accumulation
  logic signed [57:0] prod_r;
  logic active;
  logic [32:0] wp;
  bundle_t out_nxt;

  assign active = CNT_W'(OCT) < cfg.octaves;
  assign wp = dly_r[DLY-1].weight * cfg.persistence;

  always_ff @(posedge clk) begin
    prod_r <= val_r * $signed({1'b0, dly_r[DLY-2].weight});
  end

  always_comb begin
    out_nxt = dly_r[DLY-1];
    if (active) begin
      out_nxt.sum = dly_r[DLY-1].sum + SUM_W'(prod_r);
      out_nxt.total = dly_r[DLY-1].total + TOT_W'(dly_r[DLY-1].weight);
      out_nxt.weight = wp[32:16];
    end
  end

  always_ff @(posedge clk) begin
    out_b <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[DLY-1];
    end
  end

endmodule

`default_nettype wire

@@ src/gnf_div.sv @@
`default_nettype none

module gnf_div
  import gnf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic signed [SUM_W-1:0] in_sum,
  input  wire logic [TOT_W-1:0]        in_total,
  output logic                         out_valid,
  output logic [15:0]                  out_value
);

  localparam int QB = 17;
  localparam int D_W = TOT_W + 16;

  logic [SUM_W-2:0] rem_r [QB+1];
  logic [D_W-1:0]   d_r   [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             v_r   [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= (in_sum > 0) ? in_sum[SUM_W-2:0] : '0;
    d_r[0] <= {in_total, 16'd0};
    q_r[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  // restoring division, one quotient bit a stage
  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int SHF = QB - j;
    logic [SUM_W-1:0] trial;

    assign trial = {1'b0, rem_r[j-1]} - ({{(SUM_W-D_W){1'b0}}, d_r[j-1]} << SHF);

    always_ff @(posedge clk) begin
      rem_r[j] <= trial[SUM_W-1] ? rem_r[j-1] : trial[SUM_W-2:0];
      d_r[j] <= d_r[j-1];
      q_r[j] <= q_r[j-1] | ({{(QB-1){1'b0}}, ~trial[SUM_W-1]} << SHF);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_value <= q_r[QB][QB-1] ? 16'hFFFF : q_r[QB][15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[QB];
    end
  end

endmodule

`default_nettype wire

@@ src/gradient_noise_fbm.sv @@
`default_nettype none

// fractal gradient noise over a 2d point
// input: start with in_x_coord / in_y_coord (signed q16.16); an item is taken
// at any clock edge with start high and busy low. busy stays low, so a new
// item may be offered every cycle
// output: out_valid is high for one cycle with out_noise_value (q0.16)
// throughput: one item per cycle, set by the row of octave cells, each a
// twelve-stage pipeline handing its partial sums to the next cell, and the
// seventeen-stage quotient pipeline behind it
// configuration: cfg_we writes cfg_wdata to register cfg_index (seed,
// scale_recip, octave_count, persistence) at the clock edge; write only
// while no item is in flight
// reset: synchronous, clears all valid flags and loads the register
// defaults; items in flight are dropped
// the receiver cannot stall: every result appears for exactly one cycle
module gradient_noise_fbm
  import gnf_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  output logic                    out_valid,
  output logic [15:0]             out_noise_value,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  logic [31:0] seed_r;
  logic [23:0] scale_r;
  logic [3:0]  oct_r;
  logic [15:0] pers_r;
  logic [63:0] seed_term_r;
  logic [CNT_W-1:0] eff_count_r;
  logic [62:0] seed_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
      scale_r <= 24'd65536;
      oct_r <= 4'd1;
      pers_r <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:        seed_r <= cfg_wdata;
        REG_SCALE_RECIP: scale_r <= cfg_wdata[23:0];
        REG_OCTAVES:     oct_r <= cfg_wdata[3:0];
        REG_PERSISTENCE: pers_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign seed_prod = seed_r * K_SEED;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_count_r <= CNT_W'(1);
    end else if (oct_r == 4'd0) begin
      eff_count_r <= CNT_W'(1);
    end else if ({1'b0, oct_r} > CNT_W'(MAX_OCTAVES)) begin
      eff_count_r <= CNT_W'(MAX_OCTAVES);
    end else begin
      eff_count_r <= {1'b0, oct_r};
    end
  end

  always_ff @(posedge clk) begin
    seed_term_r <= {1'b0, seed_prod};
  end

  cfg_t cfg;
  assign cfg.seed_term = seed_term_r;
  assign cfg.persistence = pers_r;
  assign cfg.octaves = eff_count_r;

  assign busy = 1'b0;

  // input capture and scaling
  logic in_vld_r, p_vld_r;
  logic signed [31:0] x_r, y_r;
  logic signed [P_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
      p_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= in_x_coord;
    y_r <= in_y_coord;
    px_r <= x_r * $signed({1'b0, scale_r});
    py_r <= y_r * $signed({1'b0, scale_r});
  end

  // row of octave cells
  bundle_t chain_b [MAX_OCTAVES+1];
  logic    chain_v [MAX_OCTAVES+1];

  assign chain_b[0].px = px_r;
  assign chain_b[0].py = py_r;
  assign chain_b[0].sum = '0;
  assign chain_b[0].weight = WGT_W'(65536);
  assign chain_b[0].total = '0;
  assign chain_v[0] = p_vld_r;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    gnf_cell #(
      .OCT(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg),
      .in_valid (chain_v[k]),
      .in_b     (chain_b[k]),
      .out_valid(chain_v[k+1]),
      .out_b    (chain_b[k+1])
    );
  end

  gnf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (chain_v[MAX_OCTAVES]),
    .in_sum   (chain_b[MAX_OCTAVES].sum),
    .in_total (chain_b[MAX_OCTAVES].total),
    .out_valid(out_valid),
    .out_value(out_noise_value)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("output strobe after reset");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_OCTAVES |=> ##1
      eff_count_r != '0 && eff_count_r <= CNT_W'(MAX_OCTAVES))
    else $error("octave count outside range");
  a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[MAX_OCTAVES] |-> chain_b[MAX_OCTAVES].total >= TOT_W'(65536))
    else $error("weight total below first octave");
`endif

endmodule

`default_nettype wire

@@ bench/tb_gradient_noise_fbm.sv @@
`default_nettype none

module tb_gradient_noise_fbm;
  import gnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          OCT_LIMIT  = 8;
  localparam int          LATENCY    = 12 * OCT_LIMIT + 21;
  localparam int          STALL_MAX  = 4000;
  localparam int          RAND_ITEMS = 1150;
  localparam int          PHASES     = 10;
  localparam logic [15:0] HALF_NOISE = 16'd32768;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               known;
    logic [15:0]        noise;
  } probe_t;

  // lattice aligned points give a zero fraction, hence exactly one half
  localparam probe_t PROBES [0:11] = '{
    '{32'sh00000000, 32'sh00000000, 1'b1, HALF_NOISE},
    '{32'sh80000000, 32'sh80000000, 1'b1, HALF_NOISE},
    '{32'sh7F000000, 32'sh80000000, 1'b1, HALF_NOISE},
    '{32'sh01000000, 32'shFF000000, 1'b1, HALF_NOISE},
    '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 16'd0},
    '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, 16'd0},
    '{32'sh00000001, 32'shFFFFFFFF, 1'b0, 16'd0},
    '{32'sh00008000, 32'sh00008000, 1'b0, 16'd0},
    '{32'sh00800000, 32'sh00000000, 1'b0, 16'd0},
    '{32'shFFFFFFFF, 32'sh00000000, 1'b0, 16'd0},
    '{32'sh12345678, 32'sh9ABCDEF0, 1'b0, 16'd0},
    '{32'sh00FFFFFF, 32'sh00FFFFFF, 1'b0, 16'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic               out_valid;
  logic [15:0]        out_noise_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  logic [31:0] seed_r;
  logic [23:0] scale_r;
  logic [3:0]  octaves_r;
  logic [15:0] persist_r;

  // ring of predicted noise values, in order of acceptance
  logic [15:0] exp_noise [0:255];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          idle_pct = 0;
  int          stall_cycles = 0;

  gradient_noise_fbm #(.MAX_OCTAVES(OCT_LIMIT)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] corner_grad(longint cx, longint cy);
    logic [63:0] h;
    h = 64'(cx) * 64'd374761393 + 64'(cy) * 64'd668265263
      + {32'd0, seed_r} * 64'd1442695041;
    h = h ^ (h >> 13);
    h = h * 64'd1274126177;
    h = h ^ (h >> 16);
    if (h[31:0] == 32'hFFFFFFFF) return GR_PX;
    return h[31:29];
  endfunction

  function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy);
    longint gx;
    longint gy;
    case (corner_grad(cx, cy))
      GR_PX:   begin gx = 65536;  gy = 0;      end
      GR_NX:   begin gx = -65536; gy = 0;      end
      GR_PY:   begin gx = 0;      gy = 65536;  end
      GR_NY:   begin gx = 0;      gy = -65536; end
      GR_PP:   begin gx = 46341;  gy = 46341;  end
      GR_NP:   begin gx = -46341; gy = 46341;  end
      GR_PN:   begin gx = 46341;  gy = -46341; end
      default: begin gx = -46341; gy = -46341; end
    endcase
    return gx * dx + gy * dy;
  endfunction

  function automatic longint smoothstep(longint f);
    return ((f * f) * (196608 - 2 * f)) >>> 32;
  endfunction

  function automatic longint mix(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint octave_noise(longint px, longint py, int k);
    longint ix, iy, fx, fy, u, v, a, b, n;
    ix = px >>> (40 - k);
    iy = py >>> (40 - k);
    fx = (px >> (24 - k)) & 64'hFFFF;
    fy = (py >> (24 - k)) & 64'hFFFF;
    u  = smoothstep(fx);
    v  = smoothstep(fy);
    a  = mix(corner_dot(ix, iy, fx, fy), corner_dot(ix + 1, iy, fx - 65536, fy), u);
    b  = mix(corner_dot(ix, iy + 1, fx, fy - 65536),
             corner_dot(ix + 1, iy + 1, fx - 65536, fy - 65536), u);
    n  = mix(a, b, v);
    return (n >>> 1) + (longint'(1) << 31);
  endfunction

  function automatic logic [15:0] fbm_noise(logic signed [31:0] x, logic signed [31:0] y);
    longint px, py, weight, total, sum, q;
    int     cnt;
    px     = longint'(x) * longint'(scale_r);
    py     = longint'(y) * longint'(scale_r);
    cnt    = (octaves_r < 1) ? 1 : (octaves_r > OCT_LIMIT) ? OCT_LIMIT : int'(octaves_r);
    weight = 65536;
    total  = 0;
    sum    = 0;
    for (int k = 0; k < cnt; k++) begin
      sum    += octave_noise(px, py, k) * weight;
      total  += weight;
      weight  = (weight * longint'(persist_r)) >> 16;
    end
    if (sum <= 0) return 16'd0;
    q = sum / (total << 16);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic add_expected(logic [15:0] value);
    exp_noise[exp_wr[7:0]] = value;
    exp_wr++;
  endtask

  task automatic settle();
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEED:        seed_r    = data;
      REG_SCALE_RECIP: scale_r   = data[23:0];
      REG_OCTAVES:     octaves_r = data[3:0];
      default:         persist_r = data[15:0];
    endcase
  endtask

  task automatic configure(logic [31:0] seed, logic [23:0] scale, logic [3:0] oct,
                           logic [15:0] pers);
    // upper bits carry junk to exercise masking
    settle();
    write_reg(REG_SEED, seed);
    write_reg(REG_SCALE_RECIP, {8'($urandom), scale});
    write_reg(REG_OCTAVES, {28'($urandom), oct});
    write_reg(REG_PERSISTENCE, {16'($urandom), pers});
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic known,
                            logic [15:0] noise);
    idle_pct = (items_sent < 400) ? 35 : (items_sent < 800) ? 72 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (busy);
    add_expected(known ? noise : fbm_noise(x, y));
    items_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
      1:       return $urandom & 32'hFF000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    seed_r    = '0;
    scale_r   = 24'd65536;
    octaves_r = 4'd1;
    persist_r = 16'd32768;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i]) send_point(PROBES[i].x, PROBES[i].y, PROBES[i].known, PROBES[i].noise);

    for (int p = 0; p < PHASES; p++) begin
      start <= 1'b0;
      case (p)
        0:       configure(32'hFFFFFFFF, 24'hFFFFFF, 4'd8, 16'hFFFF);
        1:       configure($urandom, 24'd1, 4'd15, 16'd0);
        2:       configure(32'd0, 24'd0, 4'd0, 16'h8000);
        3:       configure($urandom, 24'($urandom), 4'd4, 16'($urandom));
        4:       configure($urandom, 24'($urandom_range(1, 24'h20000)), 4'd8,
                           16'($urandom));
        default: configure($urandom, 24'($urandom), 4'($urandom), 16'($urandom));
      endcase
      repeat (RAND_ITEMS / PHASES) send_point(rand_coord(), rand_coord(), 1'b0, 16'd0);
    end
    start <= 1'b0;

    settle();
    repeat (LATENCY + 20) @(posedge clk);
    if (exp_wr != exp_rd) begin
      $display("%0t noise missing: %0d results never arrived", $time, exp_wr - exp_rd);
      errors++;
    end
    $display("%0d points sent (%0d directed), %0d results checked, %0d config phases",
             items_sent, $size(PROBES), results_seen, PHASES + 1);
    $display("seed, scale, octave and persistence extremes covered, sender idle 35/72/0 pct");
    if (errors == 0) $display("tb_gradient_noise_fbm OK");
    else $display("tb_gradient_noise_fbm NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        $display("%0t noise mismatch: expected none got %0d", $time, out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== exp_noise[exp_rd[7:0]]) begin
          $display("%0t noise mismatch: expected %0d got %0d", $time,
                   exp_noise[exp_rd[7:0]], out_noise_value);
          errors++;
        end
        exp_rd++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("%0t timeout waiting for progress", $time);
      $display("tb_gradient_noise_fbm NOT OK");
      $finish;
    end
  end

endmodule

`default_nettype wire
